FILE: design/cps_pkg.sv
// Shared types, constants and saturation helpers for the cascade PID setpoint block.
// No dependencies; every other design file imports this package.
package cps_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Integrator runs once every INTEGRAL_PERIOD+1 active requests
    localparam int TICK_W = 6;
    localparam logic [TICK_W-1:0] INTEGRAL_PERIOD = TICK_W'(60);

    // Internal queue geometry (work queue and result queue)
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Temperature codes
    localparam logic signed [15:0] TEMP_INVALID  = 16'sh8000;
    localparam logic signed [17:0] FRIDGE_MARGIN = 18'sd1024;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEER_TARGET  = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_INT_ERR_LIM  = 3'd4,
        CFG_SP_FLOOR     = 3'd5,
        CFG_SP_CEILING   = 3'd6,
        CFG_MAX_OFFSET   = 3'd7
    } t_cfg_idx;

    // Classification of an accepted request
    typedef enum logic [1:0] {
        KIND_HOLD    = 2'd0,   // not in beer mode: setpoint unchanged
        KIND_INVALID = 2'd1,   // beer setpoint marked invalid
        KIND_ACTIVE  = 2'd2    // full PID evaluation
    } t_kind;

    typedef struct packed {
        logic signed [15:0] beer_slow_temp;
        logic signed [15:0] beer_slope;
        logic signed [15:0] fridge_fast_temp;
        logic               ctrl_idle;
        logic               beer_mode;
    } t_cps_in;

    typedef struct packed {
        logic signed [15:0] fridge_target;
        logic signed [15:0] p_term;
        logic signed [31:0] i_term;
        logic signed [15:0] d_term;
    } t_cps_out;

    typedef struct packed {
        logic signed [15:0] beer_target;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic        [14:0] integral_error_limit;
        logic signed [15:0] setpoint_floor;
        logic signed [15:0] setpoint_ceiling;
        logic        [14:0] max_offset;
    } t_cps_cfg;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        t_kind              kind;
        logic               tick;
        logic               ctrl_idle;
        logic signed [15:0] err;
        logic signed [15:0] p_term;
        logic signed [15:0] d_term;
        logic signed [15:0] fridge_fast_temp;
    } t_cps_work;

    // Back end: integrator stage to setpoint stage
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] acc;
        logic signed [15:0] p_term;
        logic signed [15:0] d_term;
    } t_cps_stage;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)       r = 16'sh7FFF;
        else if (v < -40'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

FILE: design/cps_front.sv
// Front end: classifies each accepted request, forms the error, P and D terms
// and owns the integrator tick counter. Depends on cps_pkg.
module cps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cps_pkg::t_cps_cfg   i_cfg,
    input  logic                i_accept,
    input  cps_pkg::t_cps_in    i_item,
    output cps_pkg::t_cps_work  o_work
);
    import cps_pkg::*;

    logic [TICK_W-1:0]  r_tick_cnt, n_tick_cnt;
    logic signed [16:0] w_diff;
    logic signed [15:0] w_err;
    logic signed [31:0] w_prod_p, w_prod_d;
    t_kind              w_kind;
    logic               w_tick;

    // Error, saturated to 16 bits
    assign w_diff = 17'(i_cfg.beer_target) - 17'(i_item.beer_slow_temp);
    assign w_err  = sat16(40'(w_diff));

    // Proportional and derivative products, floor-scaled by 2^-9
    assign w_prod_p = i_cfg.gain_p * w_err;
    assign w_prod_d = i_cfg.gain_d * i_item.beer_slope;

    // Classification
    always_comb begin
        if (!i_item.beer_mode)                    w_kind = KIND_HOLD;
        else if (i_cfg.beer_target == TEMP_INVALID) w_kind = KIND_INVALID;
        else                                      w_kind = KIND_ACTIVE;
    end

    assign w_tick = (w_kind == KIND_ACTIVE) && (r_tick_cnt >= INTEGRAL_PERIOD);

    // Tick counter advances only on active requests
    always_comb begin
        n_tick_cnt = r_tick_cnt;
        if (i_accept && w_kind == KIND_ACTIVE) begin
            n_tick_cnt = w_tick ? '0 : r_tick_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tick_cnt <= '0;
        else          r_tick_cnt <= n_tick_cnt;
    end

    assign o_work.kind             = w_kind;
    assign o_work.tick             = w_tick;
    assign o_work.ctrl_idle        = i_item.ctrl_idle;
    assign o_work.err              = w_err;
    assign o_work.p_term           = sat16(40'(w_prod_p >>> 9));
    assign o_work.d_term           = sat16(40'(w_prod_d >>> 9));
    assign o_work.fridge_fast_temp = i_item.fridge_fast_temp;

endmodule

FILE: design/cps_work_fifo.sv
// Short queue of classified requests between the front and back ends.
// Depends on cps_pkg.
module cps_work_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  cps_pkg::t_cps_work  i_wr_item,
    output logic                o_full,
    input  logic                i_rd,
    output logic                o_valid,
    output cps_pkg::t_cps_work  o_rd_item
);
    import cps_pkg::*;

    t_cps_work         r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_wr, w_rd;

    assign o_full    = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rd_item = r_mem[r_rd_ptr];
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= r_cnt + CNT_W'(w_wr) - CNT_W'(w_rd);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_wr_item;
    end

endmodule

FILE: design/cps_back.sv
// Back end: integrator update, I term, setpoint sum and clamp, result queue.
// Depends on cps_pkg.
module cps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cps_pkg::t_cps_cfg   i_cfg,
    input  logic                i_q_valid,
    input  cps_pkg::t_cps_work  i_q_item,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output cps_pkg::t_cps_out   o_item
);
    import cps_pkg::*;

    // State
    logic signed [31:0] r_acc;
    logic signed [15:0] r_fs;
    logic               r_s1_valid;
    t_cps_stage         r_s1;

    // Result queue
    t_cps_out          r_out_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_out_cnt;

    logic               w_a_fire, w_b_fire, w_pop_fire;

    // Common bound operands, 18-bit signed
    logic signed [17:0] w_bt18, w_fs18, w_floor18, w_ceil18, w_mo18, w_ff18;

    // Integrator stage signals
    logic signed [16:0] w_err17;
    logic        [16:0] w_abs_err;
    logic               w_small, w_up_pos, w_acc_pos, w_hold;
    logic signed [33:0] w_upd;
    logic signed [31:0] w_acc_next;

    // Setpoint stage signals
    logic signed [47:0] w_prod_i;
    logic signed [31:0] w_i_term;
    logic signed [33:0] w_sum34;
    logic signed [17:0] w_sum18, w_lo18, w_hi18, w_clamp18;
    t_cps_out           w_result;

    assign w_bt18    = 18'(i_cfg.beer_target);
    assign w_fs18    = 18'(r_fs);
    assign w_floor18 = 18'(i_cfg.setpoint_floor);
    assign w_ceil18  = 18'(i_cfg.setpoint_ceiling);
    assign w_mo18    = $signed({3'b000, i_cfg.max_offset});
    assign w_ff18    = 18'(i_q_item.fridge_fast_temp);

    // Handshakes: a tick request reads the setpoint, so it waits until the
    // request ahead of it has left the setpoint stage
    assign w_b_fire   = r_s1_valid && (r_out_cnt != CNT_W'(FIFO_DEPTH));
    assign w_a_fire   = i_q_valid && (!r_s1_valid || w_b_fire)
                        && !(i_q_item.tick && r_s1_valid);
    assign o_q_pop    = w_a_fire;
    assign w_pop_fire = i_pop && !o_empty;

    // Anti-windup integrator update
    assign w_err17   = 17'(i_q_item.err);
    assign w_abs_err = (w_err17 < 0) ? 17'(-w_err17) : 17'(w_err17);
    assign w_small   = w_abs_err < {2'b00, i_cfg.integral_error_limit};
    assign w_up_pos  = i_q_item.err > 0;
    assign w_acc_pos = r_acc > 0;
    assign w_hold    = (w_fs18 >= w_ceil18) || (w_fs18 <= w_floor18)
                       || (w_fs18 - w_bt18 >= w_mo18) || (w_bt18 - w_fs18 >= w_mo18)
                       || (!w_up_pos && w_ff18 > w_fs18 + FRIDGE_MARGIN)
                       || (w_up_pos && w_ff18 < w_fs18 - FRIDGE_MARGIN);

    always_comb begin
        if (!i_q_item.ctrl_idle) begin
            w_upd = '0;
        end else if (w_small) begin
            if (w_up_pos == w_acc_pos) w_upd = w_hold ? 34'sd0 : 34'(i_q_item.err);
            else                       w_upd = 34'(i_q_item.err) <<< 1;
        end else begin
            w_upd = -(34'(r_acc >>> 3));
        end
    end

    assign w_acc_next = sat32(40'(34'(r_acc) + w_upd));

    // Integral register and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_a_fire && i_q_item.tick) r_acc <= w_acc_next;
            if (w_a_fire)                  r_s1_valid <= 1'b1;
            else if (w_b_fire)             r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire) begin
            r_s1.kind   <= i_q_item.kind;
            r_s1.acc    <= i_q_item.tick ? w_acc_next : r_acc;
            r_s1.p_term <= i_q_item.p_term;
            r_s1.d_term <= i_q_item.d_term;
        end
    end

    // I term and setpoint sum
    assign w_prod_i = i_cfg.gain_i * r_s1.acc;
    assign w_i_term = sat32(40'(w_prod_i >>> 9));
    assign w_sum34  = 34'(i_cfg.beer_target) + 34'(r_s1.p_term) + 34'(w_i_term)
                      + 34'(r_s1.d_term);
    assign w_sum18  = 18'(sat16(40'(w_sum34)));

    // Bounds around beer setpoint; crossed: sum < lo gets lo, else hi
    assign w_lo18 = (w_bt18 <= w_floor18 + w_mo18) ? w_floor18 : w_bt18 - w_mo18;
    assign w_hi18 = (w_bt18 >= w_ceil18 - w_mo18)  ? w_ceil18  : w_bt18 + w_mo18;

    always_comb begin
        if (w_sum18 < w_lo18)      w_clamp18 = w_lo18;
        else if (w_sum18 > w_hi18) w_clamp18 = w_hi18;
        else                       w_clamp18 = w_sum18;
    end

    // Result per request kind
    always_comb begin
        w_result = '0;
        unique case (r_s1.kind)
            KIND_HOLD: begin
                w_result.fridge_target = r_fs;
            end
            KIND_INVALID: begin
                w_result.fridge_target = TEMP_INVALID;
            end
            KIND_ACTIVE: begin
                w_result.fridge_target = w_clamp18[15:0];
                w_result.p_term        = r_s1.p_term;
                w_result.i_term        = w_i_term;
                w_result.d_term        = r_s1.d_term;
            end
            default: begin
                w_result.fridge_target = r_fs;
            end
        endcase
    end

    // Fridge setpoint register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= TEMP_INVALID;
        end else if (w_b_fire) begin
            r_fs <= w_result.fridge_target;
        end
    end

    // Result queue control
    assign o_empty = (r_out_cnt == '0);
    assign o_item  = r_out_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (w_b_fire)   r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop_fire) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_out_cnt <= r_out_cnt + CNT_W'(w_b_fire) - CNT_W'(w_pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_fire) r_out_mem[r_wr_ptr] <= w_result;
    end

endmodule

FILE: design/cascade_pid_setpoint.sv
// Cascade PID fridge setpoint. An accepted request passes through the work queue, the
// integrator stage and the setpoint stage, then into the result queue behind the result ports.
// Throughput: one request per cycle while the result queue has room, except that an
// integrator-tick request waits while the request ahead is still in the setpoint stage
// (setpoint feedback loop).
// Reset is synchronous: queues empty, integral and tick count zero, setpoint
// invalid, configuration registers at their defaults.
module cascade_pid_setpoint (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  cps_pkg::t_cps_in                    i_in_item,
    output logic                                empty,
    input  logic                                pop,
    output cps_pkg::t_cps_out                   o_out_item,
    input  logic                                i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cps_pkg::*;

    t_cps_cfg   r_cfg;
    t_cps_work  w_work, w_q_item;
    logic       w_accept, w_q_valid, w_q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beer_target          <= TEMP_INVALID;
            r_cfg.gain_p               <= 16'sd2560;
            r_cfg.gain_i               <= 16'sd128;
            r_cfg.gain_d               <= -16'sd768;
            r_cfg.integral_error_limit <= 15'd256;
            r_cfg.setpoint_floor       <= -16'sd32767;
            r_cfg.setpoint_ceiling     <= 16'sd32767;
            r_cfg.max_offset           <= 15'd5120;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BEER_TARGET: r_cfg.beer_target          <= i_cfg_data;
                CFG_GAIN_P:      r_cfg.gain_p               <= i_cfg_data;
                CFG_GAIN_I:      r_cfg.gain_i               <= i_cfg_data;
                CFG_GAIN_D:      r_cfg.gain_d               <= i_cfg_data;
                CFG_INT_ERR_LIM: r_cfg.integral_error_limit <= i_cfg_data[14:0];
                CFG_SP_FLOOR:    r_cfg.setpoint_floor       <= i_cfg_data;
                CFG_SP_CEILING:  r_cfg.setpoint_ceiling     <= i_cfg_data;
                CFG_MAX_OFFSET:  r_cfg.max_offset           <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign w_accept = push && !full;

    // Front end: classify and form P, D
    cps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_work   (w_work)
    );

    // Decoupling queue
    cps_work_fifo u_work_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (w_work),
        .o_full    (full),
        .i_rd      (w_q_pop),
        .o_valid   (w_q_valid),
        .o_rd_item (w_q_item)
    );

    // Back end: integrator, setpoint, results
    cps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

FILE: test/tb_cascade_pid_setpoint.sv
// Self-checking testbench for cascade_pid_setpoint: random and directed PID requests,
// an in-bench setpoint predictor, and random stalls on both queue sides.
// Depends on cps_pkg (design/cps_pkg.sv) and the cascade_pid_setpoint RTL.
`timescale 1ns / 100ps

module tb_cascade_pid_setpoint;
    import cps_pkg::*;

    localparam int     NUM_PHASES      = 8;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     HOLD_CYCLES     = 80;
    localparam int     WATCHDOG_LIMIT  = 1000;
    localparam int     MAX_PRINTS      = 100;
    localparam longint S16_MAX         = 64'sd32767;
    localparam longint S16_MIN         = -S16_MAX - 1;
    localparam longint S32_MAX         = 64'sd2147483647;
    localparam longint S32_MIN         = -S32_MAX - 1;

    // DUT ports; the inputs are at known values from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    t_cps_in               i_in_item  = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_cps_out              o_out_item;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: register copy, integrator, held setpoint, tick counter
    logic [15:0]        cfg_regs [8];
    logic [15:0]        next_regs [8];
    logic signed [31:0] integral_sum;
    logic signed [15:0] fridge_sp;
    logic [TICK_W-1:0]  tick_cnt;

    t_cps_in  sample_q [$];
    t_cps_out due_setpoints [$];

    // Bookkeeping
    int  n_queued    = 0;
    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_ticks     = 0;
    int  n_settings  = 0;
    int  n_full      = 0;
    int  err_cnt     = 0;
    int  idle_cycles = 0;
    int  gap_pct     = 0;
    int  stall_pct   = 0;
    bit  hold_arm    = 1'b0;
    bit  in_fire     = 1'b0;

    // Sender side state
    int  gap_left    = 0;
    // Receiver side state
    int  stall_left  = 0;
    int  hold_left   = 0;
    bit  hold_used   = 1'b0;

    cascade_pid_setpoint u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sreg(t_cfg_idx k);
        return longint'($signed(cfg_regs[k]));
    endfunction

    function automatic logic [15:0] to_q16(longint v);
        return 16'(clamp(v, -S16_MAX, S16_MAX));
    endfunction

    // One PID evaluation; advances the integrator and setpoint state
    function automatic t_cps_out pid_setpoint_calc(t_cps_in r);
        t_cps_out o;
        longint   bt, fs, ff, err, upd, p, ii, d, sum, lo, hi, flr, ceil_v, moff;
        bit       up_pos, acc_pos;
        p  = 0;
        ii = 0;
        d  = 0;
        if (r.beer_mode && cfg_regs[CFG_BEER_TARGET] == TEMP_INVALID) begin
            fridge_sp = TEMP_INVALID;
        end else if (r.beer_mode) begin
            bt     = sreg(CFG_BEER_TARGET);
            flr    = sreg(CFG_SP_FLOOR);
            ceil_v = sreg(CFG_SP_CEILING);
            moff   = sreg(CFG_MAX_OFFSET);
            fs     = longint'(fridge_sp);
            ff     = longint'($signed(r.fridge_fast_temp));
            err    = clamp(bt - longint'($signed(r.beer_slow_temp)), S16_MIN, S16_MAX);

            if (tick_cnt >= INTEGRAL_PERIOD) begin
                tick_cnt = '0;
                n_ticks++;
                upd = err;
                if (!r.ctrl_idle) begin
                    upd = 0;
                end else if ((err < 0 ? -err : err) < sreg(CFG_INT_ERR_LIM)) begin
                    up_pos  = err > 0;
                    acc_pos = integral_sum > 0;
                    if (up_pos == acc_pos) begin
                        // anti-windup: hold the integral when the output is pinned
                        if (fs >= ceil_v) upd = 0;
                        if (fs <= flr) upd = 0;
                        if (fs - bt >= moff) upd = 0;
                        if (bt - fs >= moff) upd = 0;
                        if (!up_pos && ff > fs + longint'(FRIDGE_MARGIN)) upd = 0;
                        if (up_pos && ff < fs - longint'(FRIDGE_MARGIN)) upd = 0;
                    end else begin
                        upd = err * 2;
                    end
                end else begin
                    upd = -(longint'(integral_sum) >>> 3);
                end
                integral_sum = 32'(clamp(longint'(integral_sum) + upd, S32_MIN, S32_MAX));
            end else begin
                tick_cnt = tick_cnt + 1'b1;
            end

            p  = clamp((sreg(CFG_GAIN_P) * err) >>> 9, S16_MIN, S16_MAX);
            ii = clamp((sreg(CFG_GAIN_I) * longint'(integral_sum)) >>> 9, S32_MIN, S32_MAX);
            d  = clamp((sreg(CFG_GAIN_D) * longint'($signed(r.beer_slope))) >>> 9,
                       S16_MIN, S16_MAX);

            // sum, then the bounds; when they cross, a sum below the lower bound takes it, any other sum the upper
            sum = clamp(bt + p + ii + d, S16_MIN, S16_MAX);
            lo  = (bt <= flr + moff) ? flr : bt - moff;
            hi  = (bt >= ceil_v - moff) ? ceil_v : bt + moff;
            if (sum < lo) sum = lo;
            else if (sum > hi) sum = hi;
            fridge_sp = 16'(sum);
        end
        o.fridge_target = fridge_sp;
        o.p_term        = 16'(p);
        o.i_term        = 32'(ii);
        o.d_term        = 16'(d);
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_cnt < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      n_results, name, got, want));
    endtask

    // Driver: offers queued requests, holds each until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            gap_left <= 0;
        end else if (push && !in_fire) begin
            // offer still pending
        end else if (gap_left != 0) begin
            push     <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
            push     <= 1'b0;
            gap_left <= $urandom_range(0, 2);
        end else if (sample_q.size() != 0) begin
            push      <= 1'b1;
            i_in_item <= sample_q.pop_front();
        end else begin
            push <= 1'b0;
        end
    end

    // Receiver: random short stalls plus one long hold-off when armed
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_used  <= 1'b0;
        end else if (hold_left != 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            pop       <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            pop <= 1'b1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results, watchdog
    always @(posedge i_clk) begin : monitor
        t_cps_out want;
        if (!i_rst_n) begin
            in_fire     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire <= push && !full;
            if (push && !full) begin
                due_setpoints.push_back(pid_setpoint_calc(i_in_item));
                n_accepted++;
            end
            if (push && full) n_full++;
            if (pop && !empty) begin
                if (due_setpoints.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing due",
                                              n_results));
                end else begin
                    want = due_setpoints.pop_front();
                    check_field("fridge_target", longint'($signed(o_out_item.fridge_target)),
                                longint'($signed(want.fridge_target)));
                    check_field("p_term", longint'($signed(o_out_item.p_term)),
                                longint'($signed(want.p_term)));
                    check_field("i_term", longint'($signed(o_out_item.i_term)),
                                longint'($signed(want.i_term)));
                    check_field("d_term", longint'($signed(o_out_item.d_term)),
                                longint'($signed(want.d_term)));
                end
                n_results++;
            end
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_item(logic [15:0] bs, logic [15:0] sl, logic [15:0] ff,
                              logic idle, logic bm);
        t_cps_in r;
        r.beer_slow_temp   = bs;
        r.beer_slope       = sl;
        r.fridge_fast_temp = ff;
        r.ctrl_idle        = idle;
        r.beer_mode        = bm;
        sample_q.push_back(r);
        n_queued++;
    endtask

    // Writes all eight registers from next_regs, back to back
    task automatic load_settings();
        for (int k = 0; k < 8; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[CFG_IDX_W-1:0];
            i_cfg_data <= next_regs[k];
            if (k == CFG_INT_ERR_LIM || k == CFG_MAX_OFFSET)
                cfg_regs[k] = next_regs[k] & 16'h7FFF;
            else
                cfg_regs[k] = next_regs[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || due_setpoints.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_gain();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    // Register set for one random phase; a few phases pin the extremes
    task automatic pick_settings(int ph);
        longint bt;
        logic [15:0] tmp;
        bt = longint'(int'($urandom_range(0, 32000)) - 16000);
        next_regs[CFG_BEER_TARGET] = to_q16(bt);
        next_regs[CFG_GAIN_P]      = rand_gain();
        next_regs[CFG_GAIN_I]      = rand_gain();
        next_regs[CFG_GAIN_D]      = rand_gain();
        next_regs[CFG_INT_ERR_LIM] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(16, 2048));
        next_regs[CFG_MAX_OFFSET]  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(256, 8000));
        if ($urandom_range(0, 3) == 0) begin
            next_regs[CFG_SP_FLOOR]   = to_q16(longint'($signed(16'($urandom))));
            next_regs[CFG_SP_CEILING] = to_q16(longint'($signed(16'($urandom))));
        end else begin
            next_regs[CFG_SP_FLOOR]   = to_q16(bt - longint'($urandom_range(0, 12000)));
            next_regs[CFG_SP_CEILING] = to_q16(bt + longint'($urandom_range(0, 12000)));
        end
        case (ph)
            0: begin
                next_regs[CFG_GAIN_P]      = 16'h7FFF;
                next_regs[CFG_GAIN_I]      = 16'h7FFF;
                next_regs[CFG_GAIN_D]      = 16'h7FFF;
                next_regs[CFG_INT_ERR_LIM] = 16'hFFFF;
                next_regs[CFG_MAX_OFFSET]  = 16'hFFFF;
                next_regs[CFG_SP_FLOOR]    = 16'h8001;
                next_regs[CFG_SP_CEILING]  = 16'h7FFF;
            end
            2: begin
                next_regs[CFG_BEER_TARGET] = 16'h7FFF;
                next_regs[CFG_GAIN_P]      = 16'h8000;
                next_regs[CFG_GAIN_I]      = 16'h8000;
                next_regs[CFG_GAIN_D]      = 16'h8000;
                next_regs[CFG_INT_ERR_LIM] = 16'h0000;
                next_regs[CFG_MAX_OFFSET]  = 16'h0000;
            end
            3: next_regs[CFG_BEER_TARGET] = TEMP_INVALID;
            5: begin
                // crossed bounds
                tmp = next_regs[CFG_SP_FLOOR];
                next_regs[CFG_SP_FLOOR]   = next_regs[CFG_SP_CEILING];
                next_regs[CFG_SP_CEILING] = tmp;
            end
            default: ;
        endcase
    endtask

    // Random request: mostly beer mode with readings near the setpoint
    task automatic queue_random_item();
        longint bt, span;
        logic [15:0] bs, sl, ff;
        bt   = sreg(CFG_BEER_TARGET);
        span = sreg(CFG_INT_ERR_LIM) * 2 + 8;
        if ($urandom_range(0, 3) == 0) bs = 16'($urandom);
        else bs = to_q16(bt + longint'($urandom_range(0, 32'(2 * span))) - span);
        if ($urandom_range(0, 3) == 0) sl = 16'($urandom);
        else sl = 16'(int'($urandom_range(0, 1200)) - 600);
        if ($urandom_range(0, 2) == 0) ff = 16'($urandom);
        else ff = to_q16(bt + longint'($urandom_range(0, 6000)) - 3000);
        queue_item(bs, sl, ff, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        // power-on values of the predictor
        cfg_regs[CFG_BEER_TARGET] = TEMP_INVALID;
        cfg_regs[CFG_GAIN_P]      = 16'd2560;
        cfg_regs[CFG_GAIN_I]      = 16'd128;
        cfg_regs[CFG_GAIN_D]      = 16'hFD00;
        cfg_regs[CFG_INT_ERR_LIM] = 16'd256;
        cfg_regs[CFG_SP_FLOOR]    = 16'h8001;
        cfg_regs[CFG_SP_CEILING]  = 16'h7FFF;
        cfg_regs[CFG_MAX_OFFSET]  = 16'd5120;
        integral_sum = '0;
        fridge_sp    = TEMP_INVALID;
        tick_cnt     = '0;
        gap_pct      = 20;
        stall_pct    = 20;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: invalid beer setpoint, then a request outside beer mode
        queue_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        queue_item(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
        wait_drained();

        // top setpoint, largest gains: error overflow and output saturation
        next_regs[CFG_BEER_TARGET] = 16'h7FFF;
        next_regs[CFG_GAIN_P]      = 16'h7FFF;
        next_regs[CFG_GAIN_I]      = 16'h7FFF;
        next_regs[CFG_GAIN_D]      = 16'h8000;
        next_regs[CFG_INT_ERR_LIM] = 16'hFFFF;
        next_regs[CFG_SP_FLOOR]    = 16'h8001;
        next_regs[CFG_SP_CEILING]  = 16'h7FFF;
        next_regs[CFG_MAX_OFFSET]  = 16'h7FFF;
        load_settings();
        queue_item(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        queue_item(16'h7FFF, 16'h8000, 16'h8000, 1'b0, 1'b1);
        queue_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        queue_item(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
        queue_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        queue_item(16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b1);
        wait_drained();

        // lowest valid setpoint, negative P and I gains, zero offset and crossed bounds
        next_regs[CFG_BEER_TARGET] = 16'h8001;
        next_regs[CFG_GAIN_P]      = 16'h8000;
        next_regs[CFG_GAIN_I]      = 16'h8000;
        next_regs[CFG_GAIN_D]      = 16'h7FFF;
        next_regs[CFG_INT_ERR_LIM] = 16'h0000;
        next_regs[CFG_SP_FLOOR]    = 16'h7FFF;
        next_regs[CFG_SP_CEILING]  = 16'h8001;
        next_regs[CFG_MAX_OFFSET]  = 16'h0000;
        load_settings();
        queue_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        queue_item(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1);
        queue_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        queue_item(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b1);
        queue_item(16'h8001, 16'h0001, 16'h7FFE, 1'b0, 1'b1);
        wait_drained();

        // random phases, one register set each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pick_settings(ph);
            load_settings();
            if (ph == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = (ph % 3 == 2) ? 0 : 20;
                stall_pct = (ph % 3 == 0) ? 0 : 20;
            end
            if (ph == 1) hold_arm = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_random_item();
            wait_drained();
        end

        repeat (6) @(negedge i_clk);
        if (due_setpoints.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_setpoints.size()));

        $display("Covered %0d requests over %0d register sets, %0d integrator updates,",
                 n_accepted, n_settings, n_ticks);
        $display("%0d cycles of input back-pressure, %0d mismatches.", n_full, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: cascade_pid_setpoint.f
design/cps_pkg.sv
design/cps_front.sv
design/cps_work_fifo.sv
design/cps_back.sv
design/cascade_pid_setpoint.sv
test/tb_cascade_pid_setpoint.sv
